// ===== src/fct_pkg.sv =====
// Shared constants and types for the FAT12 cluster table.
package fct_pkg;

  localparam int unsigned ENTRY_COUNT = 4096;
  localparam int unsigned ADDR_W      = $clog2(ENTRY_COUNT);
  localparam int unsigned ENTRY_W     = 12;

  localparam logic [ENTRY_W-1:0] LAST_CLUSTER_RESET = 12'd2848;
  localparam logic [ADDR_W:0]    FIRST_CLUSTER      = (ADDR_W + 1)'(2);
  localparam logic [ADDR_W:0]    ENTRY_COUNT_X      = (ADDR_W + 1)'(ENTRY_COUNT);
  localparam logic [ADDR_W-1:0]  TOP_MAX            = ADDR_W'(ENTRY_COUNT - 1);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_COUNT = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [ENTRY_W-1:0] data;
    logic               found;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

endpackage

// ===== src/fat12_cluster_table_top.sv =====
// Top level of the FAT12 cluster table: stream ports, last_cluster register, RAM and sequencer.
// After reset the table is cleared to zero by a sweep over all 4096 entries, one entry per cycle,
// during which s_axis_tready_o stays low (last_cluster writes are taken as usual). Then one
// command beat is handled at a time. The result beat of a read follows the registered RAM read;
// that of a write follows accept directly. Find-free and count-free walk the table through the
// single RAM read port, one entry per cycle; find-free stops at the first free entry. An empty
// range answers without reading the table. The next command can be accepted in the cycle after
// the result beat has been taken.
module fat12_cluster_table_top import fct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,      // last_cluster
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // index[11:0], value[23:12]
  input  logic [1:0]  s_axis_tuser_i,   // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // data[11:0], zero pad[15:12]
  output logic        m_axis_tuser_o    // found
);

  logic [ENTRY_W-1:0] last_cluster_q;
  logic [ADDR_W-1:0]  top;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  res_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cluster_q <= LAST_CLUSTER_RESET;
    end else if (cfg_we_i) begin
      last_cluster_q <= cfg_wdata_i;
    end
  end

  // clip scan range to the table
  assign top = ({1'b0, last_cluster_q} > {1'b0, ENTRY_W'(TOP_MAX)}) ? TOP_MAX
             : last_cluster_q[ADDR_W-1:0];

  fct_ram #(
    .DEPTH(ENTRY_COUNT),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr),
    .rdata_o(ram_rdata)
  );

  fct_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(s_axis_tvalid_i),
    .cmd_ready_o(s_axis_tready_o),
    .cmd_i      (cmd_e'(s_axis_tuser_i)),
    .index_i    (s_axis_tdata_i[11:0]),
    .value_i    (s_axis_tdata_i[23:12]),
    .top_i      (top),
    .ram_req_o  (ram_req),
    .ram_rdata_i(ram_rdata),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_o      (res)
  );

  assign m_axis_tdata_o = {4'b0000, res.data};
  assign m_axis_tuser_o = res.found;

endmodule

// ===== src/fct_ram.sv =====
// Single-port-write, registered-read RAM holding the cluster entries.
module fct_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 12,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fct_seq.sv =====
// Command sequencer: table clear sweep, read/write, and scan for find-free and count-free.
module fct_seq import fct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_e               cmd_i,
  input  logic [ENTRY_W-1:0] index_i,
  input  logic [ENTRY_W-1:0] value_i,
  input  logic [ADDR_W-1:0]  top_i,
  output ram_req_t           ram_req_o,
  input  logic [ENTRY_W-1:0] ram_rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e             state_q;
  logic [ADDR_W:0]    addr_q;
  logic               pend_q;
  logic [ADDR_W-1:0]  pidx_q;
  logic [ENTRY_W-1:0] cnt_q;
  cmd_e               cmd_q;
  logic               rng_q;
  res_t               res_q;

  logic accept;
  logic in_range;
  logic issue;
  logic zero;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign in_range    = ({1'b0, index_i} < ENTRY_COUNT_X);
  assign issue       = (addr_q <= {1'b0, top_i});
  assign zero        = (ram_rdata_i == '0);

  always_comb begin
    ram_req_o       = '0;
    ram_req_o.raddr = index_i[ADDR_W-1:0];
    case (state_q)
      ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = addr_q[ADDR_W-1:0];
      end
      ST_IDLE: begin
        ram_req_o.we    = accept && (cmd_i == CMD_WRITE) && in_range;
        ram_req_o.waddr = index_i[ADDR_W-1:0];
        ram_req_o.wdata = value_i;
      end
      ST_SCAN: begin
        ram_req_o.raddr = addr_q[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      pend_q  <= 1'b0;
      pidx_q  <= '0;
      cnt_q   <= '0;
      cmd_q   <= CMD_READ;
      rng_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (addr_q[ADDR_W-1:0] == TOP_MAX) begin
            addr_q  <= '0;
            state_q <= ST_IDLE;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          pend_q <= 1'b0;
          if (accept) begin
            cmd_q <= cmd_i;
            case (cmd_i)
              CMD_READ: begin
                rng_q   <= in_range;
                state_q <= ST_READ;
              end
              CMD_WRITE: begin
                res_q   <= '0;
                state_q <= ST_RESP;
              end
              default: begin
                addr_q  <= FIRST_CLUSTER;
                cnt_q   <= '0;
                state_q <= ST_SCAN;
              end
            endcase
          end
        end
        ST_READ: begin
          res_q.data  <= rng_q ? ram_rdata_i : '0;
          res_q.found <= 1'b0;
          state_q     <= ST_RESP;
        end
        ST_SCAN: begin
          pend_q <= issue;
          pidx_q <= addr_q[ADDR_W-1:0];
          if (issue) begin
            addr_q <= addr_q + 1'b1;
          end
          if (pend_q && zero && (cmd_q == CMD_FIND)) begin
            res_q.data  <= ENTRY_W'(pidx_q);
            res_q.found <= 1'b1;
            state_q     <= ST_RESP;
          end else if (pend_q && zero) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (!issue && !pend_q) begin
            res_q.data  <= (cmd_q == CMD_FIND) ? '0 : cnt_q;
            res_q.found <= 1'b0;
            state_q     <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.found |-> res_o.data >= ENTRY_W'(2))
    else $error("found cluster below first data cluster");

  a_found_only_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (cmd_q != CMD_FIND) |-> !res_o.found)
    else $error("found flag set for a non-find command");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && pend_q |-> pidx_q <= top_i)
    else $error("scan read beyond last cluster");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) || (state_q == ST_READ) |-> !ram_req_o.we)
    else $error("table written outside clear or write command");

endmodule

// ===== tb/fat12_cluster_table_top_tb.sv =====
// Self-checking testbench for the FAT12 cluster table: directed and random commands vs a table model.
`timescale 1ns / 1ps

module fat12_cluster_table_top_tb import fct_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_READ;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  fat12_cluster_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [11:0] entry_tbl [ENTRY_COUNT];
  logic [11:0] last_cluster_q = LAST_CLUSTER_RESET;
  res_t        pending_res [$];
  res_t        last_res;
  bit          no_stall = 1'b0;
  int unsigned mismatches = 0;
  int unsigned n_sent = 0;
  int unsigned n_scans = 0;
  int unsigned n_checked = 0;
  int unsigned n_cfg = 0;
  int unsigned cycle_cnt = 0;
  int          rdy_hold = 0;

  initial begin
    for (int i = 0; i < ENTRY_COUNT; i++) entry_tbl[i] = '0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic res_t table_response(cmd_e c, logic [11:0] idx, logic [11:0] val);
    res_t r;
    int   top;
    r   = '0;
    top = (last_cluster_q > TOP_MAX) ? TOP_MAX : last_cluster_q;
    case (c)
      CMD_READ: begin
        r.data = entry_tbl[idx];
      end
      CMD_WRITE: begin
        entry_tbl[idx] = val;
      end
      CMD_FIND: begin
        for (int i = FIRST_CLUSTER; i <= top; i++) begin
          if (entry_tbl[i] == '0) begin
            r.data  = 12'(i);
            r.found = 1'b1;
            break;
          end
        end
      end
      default: begin
        for (int i = FIRST_CLUSTER; i <= top; i++) begin
          if (entry_tbl[i] == '0) r.data = r.data + 12'd1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_cmd(input cmd_e c, input logic [11:0] idx, input logic [11:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, idx};
    s_tuser  <= c;
    do @(posedge clk_i); while (!s_tready);
    last_res = table_response(c, idx, val);
    pending_res.push_back(last_res);
    n_sent++;
    if (c == CMD_FIND || c == CMD_COUNT) n_scans++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() != 0);
  endtask

  task automatic set_last_cluster(input logic [11:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    last_cluster_q = v;
    n_cfg++;
  endtask

  function automatic cmd_e pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_WRITE;
    if (r < 65) return CMD_READ;
    if (r < 82) return CMD_FIND;
    return CMD_COUNT;
  endfunction

  function automatic logic [11:0] pick_index();
    int hi;
    hi = (last_cluster_q + 3 > TOP_MAX) ? TOP_MAX : last_cluster_q + 3;
    if ($urandom_range(0, 7) == 0) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, hi));
  endfunction

  function automatic logic [11:0] pick_value();
    if ($urandom_range(0, 3) == 0) return '0;
    return 12'($urandom_range(1, 4095));
  endfunction

  // table is all free after the clearing sweep, limit still at reset value
  task automatic test_reset_state();
    send_cmd(CMD_COUNT, 12'h000, 12'h000);
    send_cmd(CMD_FIND, 12'hFFF, 12'hFFF);
  endtask

  task automatic test_entry_access();
    send_cmd(CMD_WRITE, 12'h000, 12'hFFF);
    send_cmd(CMD_WRITE, 12'hFFF, 12'h555);
    send_cmd(CMD_WRITE, 12'hAAA, 12'h001);
    send_cmd(CMD_READ, 12'h000, 12'h000);
    send_cmd(CMD_READ, 12'hFFF, 12'hFFF);
    send_cmd(CMD_READ, 12'hAAA, 12'h000);
  endtask

  task automatic test_first_free_skip();
    logic [11:0] fill [8];
    fill = '{12'h00F, 12'h0F0, 12'h0FF, 12'hF00, 12'hFF0, 12'hFFF, 12'h800, 12'h001};
    for (int i = 0; i < 8; i++) send_cmd(CMD_WRITE, 12'(i + 2), fill[i]);
    send_cmd(CMD_FIND, 12'h000, 12'h000);
  endtask

  task automatic test_scan_limits();
    set_last_cluster(12'd9);
    send_cmd(CMD_FIND, 12'h000, 12'h000);
    send_cmd(CMD_COUNT, 12'h000, 12'h000);
    set_last_cluster(12'd0);
    send_cmd(CMD_FIND, 12'h000, 12'h000);
    send_cmd(CMD_COUNT, 12'h000, 12'h000);
    set_last_cluster(12'd1);
    send_cmd(CMD_FIND, 12'h000, 12'h000);
    set_last_cluster(12'd2);
    send_cmd(CMD_COUNT, 12'h000, 12'h000);
    set_last_cluster(12'hFFF);
    send_cmd(CMD_COUNT, 12'h000, 12'h000);
    send_cmd(CMD_FIND, 12'h000, 12'h000);
  endtask

  task automatic test_random_mix(input int n, input int unsigned lc_hi, input bit pause_mid);
    set_last_cluster(12'($urandom_range(2, lc_hi)));
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_idle();
      no_stall = (i >= n / 4 && i < n / 3);
      send_cmd(pick_cmd(), pick_index(), pick_value());
    end
    no_stall = 1'b0;
  endtask

  // allocate a chain from find-free results, then follow it with reads
  task automatic test_chain_alloc();
    logic [11:0] head;
    logic [11:0] prev;
    logic [11:0] cur;
    bit          have_head;
    have_head = 1'b0;
    head      = '0;
    prev      = '0;
    set_last_cluster(12'($urandom_range(8, 48)));
    for (int k = 0; k < 10; k++) begin
      send_cmd(CMD_FIND, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      if (last_res.found) begin
        cur = last_res.data;
        send_cmd(CMD_WRITE, cur, 12'hFFF);
        if (have_head) send_cmd(CMD_WRITE, prev, cur);
        else begin
          head      = cur;
          have_head = 1'b1;
        end
        prev = cur;
      end else begin
        send_cmd(CMD_WRITE, 12'($urandom_range(2, last_cluster_q)), 12'h000);
      end
    end
    if (have_head) begin
      cur = head;
      for (int k = 0; k < 12; k++) begin
        send_cmd(CMD_READ, cur, 12'($urandom_range(0, 4095)));
        cur = last_res.data;
        if (cur == 12'hFFF || cur == 12'h000) break;
      end
    end
  endtask

  task automatic test_wide_range();
    set_last_cluster(12'hFFF);
    for (int i = 0; i < 20; i++) begin
      if (i == 10) send_cmd(CMD_COUNT, 12'($urandom_range(0, 4095)), pick_value());
      else if (i == 19) send_cmd(CMD_FIND, 12'($urandom_range(0, 4095)), pick_value());
      else send_cmd(($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ,
                    12'($urandom_range(0, 4095)), pick_value());
    end
  endtask

  always @(posedge clk_i) begin
    if (no_stall) m_tready <= 1'b1;
    else if (rdy_hold > 0) rdy_hold = rdy_hold - 1;
    else begin
      m_tready <= ($urandom_range(0, 2) != 0);
      rdy_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_res.size() == 0) begin
        if (mismatches < 10) $display("unexpected result beat: data=%h found=%b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = pending_res.pop_front();
        n_checked++;
        if (m_tdata !== {4'b0, want.data} || m_tuser !== want.found) begin
          if (mismatches < 10)
            $display("result %0d mismatch: data exp=%h got=%h, found exp=%b got=%b",
                     n_checked, want.data, m_tdata, want.found, m_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending_res.size());
    $display("[fat12_cluster_table_top] ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_entry_access();
    test_first_free_skip();
    test_scan_limits();
    test_random_mix(40, 40, 1'b1);
    test_chain_alloc();
    test_random_mix(20, 300, 1'b0);
    test_wide_range();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_res.size() != 0) mismatches++;
    $display("sent %0d commands (%0d find/count scans) over %0d last_cluster settings,",
             n_sent, n_scans, n_cfg);
    $display("checked %0d result beats, %0d mismatches, %0d cycles", n_checked, mismatches,
             cycle_cnt);
    if (mismatches == 0) $display("[fat12_cluster_table_top] OK");
    else $display("[fat12_cluster_table_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/fct_pkg.sv
src/fct_ram.sv
src/fct_seq.sv
src/fat12_cluster_table_top.sv
tb/fat12_cluster_table_top_tb.sv
